/* design/dlc_pkg.sv */
`timescale 1ns / 1ps

package dlc_pkg;

  localparam int FUNC_W = 4;
  localparam int HANDLE_W = 16;
  localparam int ID_W = 32;
  localparam int KIND_W = 4;
  localparam int DISC_W = 5;
  localparam int STATE_W = 3;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [FUNC_W-1:0] FUNC_DATA_REQ = 4'd0;
  localparam logic [FUNC_W-1:0] FUNC_STATUS_REQ = 4'd1;
  localparam logic [FUNC_W-1:0] FUNC_EST_REQ = 4'd2;
  localparam logic [FUNC_W-1:0] FUNC_EST_CNF = 4'd3;
  localparam logic [FUNC_W-1:0] FUNC_EST_IND = 4'd4;
  localparam logic [FUNC_W-1:0] FUNC_REL_IND = 4'd5;
  localparam logic [FUNC_W-1:0] FUNC_REL_CNF = 4'd6;
  localparam logic [FUNC_W-1:0] FUNC_REL_REQ = 4'd7;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 4'd8;

  localparam logic [KIND_W-1:0] KIND_NONE = 4'd0;
  localparam logic [KIND_W-1:0] KIND_EST_REQ = 4'd1;
  localparam logic [KIND_W-1:0] KIND_DATA = 4'd2;
  localparam logic [KIND_W-1:0] KIND_REL_REQ = 4'd3;
  localparam logic [KIND_W-1:0] KIND_EST_IND = 4'd4;
  localparam logic [KIND_W-1:0] KIND_EST_CNF = 4'd5;
  localparam logic [KIND_W-1:0] KIND_REL_IND = 4'd6;
  localparam logic [KIND_W-1:0] KIND_REL_CNF = 4'd7;
  localparam logic [KIND_W-1:0] KIND_STATUS = 4'd8;
  localparam logic [KIND_W-1:0] KIND_DROPPED = 4'd9;

  localparam logic [STATE_W-1:0] LINK_REL = 3'd0;
  localparam logic [STATE_W-1:0] LINK_EST_WAIT = 3'd1;
  localparam logic [STATE_W-1:0] LINK_REL_DELAY = 3'd2;
  localparam logic [STATE_W-1:0] LINK_REL_WAIT = 3'd3;
  localparam logic [STATE_W-1:0] LINK_ESTAB = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTITY_ID = 1'b1;

  localparam logic [CFG_W-1:0] RELEASE_DELAY_RESET = 16'd40000;
  localparam logic [CFG_W-1:0] ENTITY_ID_RESET = 16'hffff;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DATA,
    OP_STATUS,
    OP_EVENT,
    OP_TICK
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_EST_REQ,
    EV_EST_IND,
    EV_EST_CNF,
    EV_REL_REQ,
    EV_REL_CNF,
    EV_REL_IND,
    EV_DELAY_EXPIRED
  } ev_t;

  typedef struct packed {
    op_t                 op;
    ev_t                 ev;
    logic [HANDLE_W-1:0] handle;
    logic                procs;
    logic                blocked;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic [ID_W-1:0]     id;
    logic                up;
    logic [DISC_W-1:0]   disc;
    logic [STATE_W-1:0]  state;
    logic                last;
  } res_t;

endpackage

/* design/dlc_front.sv */
`timescale 1ns / 1ps

module dlc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [dlc_pkg::FUNC_W-1:0]     func,
  input  logic [dlc_pkg::HANDLE_W-1:0]   msg_handle,
  input  logic                           processes_active,
  input  logic                           l2_blocked,
  output logic                           cmd_valid,
  output dlc_pkg::cmd_t                  cmd,
  input  logic                           cmd_pop
);

  dlc_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;
  dlc_pkg::cmd_t dec;
  logic          do_push;
  logic          do_pop;

  always_comb begin
    dec.op = dlc_pkg::OP_EVENT;
    dec.ev = dlc_pkg::EV_NONE;
    dec.handle = msg_handle;
    dec.procs = processes_active;
    dec.blocked = l2_blocked;
    case (func)
      dlc_pkg::FUNC_DATA_REQ:   dec.op = dlc_pkg::OP_DATA;
      dlc_pkg::FUNC_STATUS_REQ: dec.op = dlc_pkg::OP_STATUS;
      dlc_pkg::FUNC_EST_REQ:    dec.ev = dlc_pkg::EV_EST_REQ;
      dlc_pkg::FUNC_EST_CNF:    dec.ev = dlc_pkg::EV_EST_CNF;
      dlc_pkg::FUNC_EST_IND:    dec.ev = dlc_pkg::EV_EST_IND;
      dlc_pkg::FUNC_REL_IND:    dec.ev = dlc_pkg::EV_REL_IND;
      dlc_pkg::FUNC_REL_CNF:    dec.ev = dlc_pkg::EV_REL_CNF;
      dlc_pkg::FUNC_REL_REQ:    dec.ev = dlc_pkg::EV_REL_REQ;
      dlc_pkg::FUNC_TICK:       dec.op = dlc_pkg::OP_TICK;
      default:                  dec.op = dlc_pkg::OP_NONE;
    endcase
  end

  assign full = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

/* design/dlc_back.sv */
`timescale 1ns / 1ps

module dlc_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  dlc_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  input  logic [dlc_pkg::CFG_W-1:0]   release_delay_ticks,
  input  logic [dlc_pkg::CFG_W-1:0]   entity_id,
  output logic                        res_empty,
  output dlc_pkg::res_t               res_head,
  input  logic                        res_pop
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [14:0] SEQ_MAX = 15'h7fff;

  localparam logic [dlc_pkg::KIND_W-1:0] K_NONE = dlc_pkg::KIND_NONE;
  localparam logic [dlc_pkg::KIND_W-1:0] K_EST_REQ = dlc_pkg::KIND_EST_REQ;
  localparam logic [dlc_pkg::KIND_W-1:0] K_DATA = dlc_pkg::KIND_DATA;
  localparam logic [dlc_pkg::KIND_W-1:0] K_REL_REQ = dlc_pkg::KIND_REL_REQ;
  localparam logic [dlc_pkg::KIND_W-1:0] K_EST_IND = dlc_pkg::KIND_EST_IND;
  localparam logic [dlc_pkg::KIND_W-1:0] K_EST_CNF = dlc_pkg::KIND_EST_CNF;
  localparam logic [dlc_pkg::KIND_W-1:0] K_REL_IND = dlc_pkg::KIND_REL_IND;
  localparam logic [dlc_pkg::KIND_W-1:0] K_REL_CNF = dlc_pkg::KIND_REL_CNF;
  localparam logic [dlc_pkg::KIND_W-1:0] K_STATUS = dlc_pkg::KIND_STATUS;
  localparam logic [dlc_pkg::KIND_W-1:0] K_DROPPED = dlc_pkg::KIND_DROPPED;

  localparam logic [2:0] M_REL = dlc_pkg::LINK_REL;
  localparam logic [2:0] M_EST_WAIT = dlc_pkg::LINK_EST_WAIT;
  localparam logic [2:0] M_REL_DELAY = dlc_pkg::LINK_REL_DELAY;
  localparam logic [2:0] M_REL_WAIT = dlc_pkg::LINK_REL_WAIT;
  localparam logic [2:0] M_ESTAB = dlc_pkg::LINK_ESTAB;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PRE,
    B_FETCH,
    B_DRAIN,
    B_POST
  } bstate_t;

  bstate_t                          bstate;
  logic [2:0]                       link_mode;
  logic [dlc_pkg::CFG_W-1:0]        delay_count;
  logic                             delay_running;
  logic [14:0]                      next_sequence;
  logic [CW-1:0]                    pending_count;
  logic [dlc_pkg::HANDLE_W-1:0]     pending_queue [QUEUE_DEPTH];
  logic [dlc_pkg::HANDLE_W-1:0]     rd_data;

  logic                             pre_v;
  logic [dlc_pkg::KIND_W-1:0]       pre_kind;
  logic [dlc_pkg::HANDLE_W-1:0]     pre_handle;
  logic [dlc_pkg::ID_W-1:0]         pre_id;
  logic                             pre_up;
  logic                             drain_v;
  logic [CW-1:0]                    drain_n;
  logic [CW-1:0]                    drain_idx;
  logic                             post_v;
  logic [dlc_pkg::KIND_W-1:0]       post_kind;
  logic [CW-1:0]                    post_disc;
  logic [2:0]                       final_mode;

  logic [2:0]                       mode_next;
  logic [dlc_pkg::CFG_W-1:0]        delay_count_next;
  logic                             delay_running_next;
  logic [14:0]                      next_sequence_next;
  logic [CW-1:0]                    pending_count_next;
  logic                             pre_v_next;
  logic [dlc_pkg::KIND_W-1:0]       pre_kind_next;
  logic [dlc_pkg::HANDLE_W-1:0]     pre_handle_next;
  logic [dlc_pkg::ID_W-1:0]         pre_id_next;
  logic                             pre_up_next;
  logic                             drain_v_next;
  logic [CW-1:0]                    drain_n_next;
  logic                             post_v_next;
  logic [dlc_pkg::KIND_W-1:0]       post_kind_next;
  logic [CW-1:0]                    post_disc_next;
  logic                             wr_en;
  dlc_pkg::ev_t                     ev;
  logic                             do_activate;
  logic                             do_start;
  logic                             do_come_up;
  logic                             do_go_down;
  logic [dlc_pkg::KIND_W-1:0]       up_kind;
  logic [14:0]                      seq_wrap;

  dlc_pkg::res_t                    oq [2];
  logic                             o_wr;
  logic                             o_rd;
  logic [1:0]                       o_cnt;
  logic                             room;
  logic                             emit_v;
  dlc_pkg::res_t                    emit_res;
  logic                             do_res_pop;
  logic                             drain_end;
  logic [CW+dlc_pkg::DISC_W-1:0]    disc_ext;

  assign seq_wrap = (next_sequence >= SEQ_MAX) ? 15'd1 : next_sequence + 15'd1;
  assign cmd_pop = (bstate == B_IDLE) && cmd_valid;

  always_comb begin
    mode_next = link_mode;
    delay_count_next = delay_count;
    delay_running_next = delay_running;
    next_sequence_next = next_sequence;
    pending_count_next = pending_count;
    pre_v_next = 1'b0;
    pre_kind_next = K_NONE;
    pre_handle_next = '0;
    pre_id_next = '0;
    pre_up_next = 1'b0;
    drain_v_next = 1'b0;
    drain_n_next = '0;
    post_v_next = 1'b0;
    post_kind_next = K_NONE;
    post_disc_next = '0;
    wr_en = 1'b0;
    ev = dlc_pkg::EV_NONE;
    do_activate = 1'b0;
    do_start = 1'b0;
    do_come_up = 1'b0;
    do_go_down = 1'b0;
    up_kind = K_NONE;

    case (cmd.op)
      dlc_pkg::OP_DATA: begin
        if (link_mode == M_ESTAB) begin
          pre_v_next = 1'b1;
          pre_kind_next = K_DATA;
          pre_handle_next = cmd.handle;
          pre_id_next = {entity_id, 1'b0, next_sequence};
          next_sequence_next = seq_wrap;
        end else begin
          if (pending_count < CW'(QUEUE_DEPTH)) begin
            wr_en = 1'b1;
            pending_count_next = pending_count + CW'(1);
          end else begin
            pre_v_next = 1'b1;
            pre_kind_next = K_DROPPED;
            pre_handle_next = cmd.handle;
          end
          ev = dlc_pkg::EV_EST_REQ;
        end
      end
      dlc_pkg::OP_STATUS: begin
        pre_v_next = 1'b1;
        pre_kind_next = K_STATUS;
        pre_up_next = (link_mode == M_ESTAB);
      end
      dlc_pkg::OP_EVENT: ev = cmd.ev;
      dlc_pkg::OP_TICK: begin
        if (delay_running) begin
          if (delay_count > 16'd1) begin
            delay_count_next = delay_count - 16'd1;
          end else begin
            delay_count_next = '0;
            delay_running_next = 1'b0;
            ev = dlc_pkg::EV_DELAY_EXPIRED;
          end
        end
      end
      default: ;
    endcase

    if (ev != dlc_pkg::EV_NONE) begin
      case (link_mode)
        M_REL: begin
          if (ev == dlc_pkg::EV_EST_REQ) begin
            do_activate = 1'b1;
          end else if (ev == dlc_pkg::EV_EST_IND || ev == dlc_pkg::EV_EST_CNF) begin
            do_come_up = 1'b1;
            up_kind = K_EST_IND;
          end
        end
        M_EST_WAIT: begin
          if (ev == dlc_pkg::EV_EST_CNF) begin
            do_come_up = 1'b1;
            up_kind = K_EST_CNF;
          end else if (ev == dlc_pkg::EV_REL_REQ) begin
            do_start = 1'b1;
          end else if (ev == dlc_pkg::EV_REL_IND) begin
            do_go_down = 1'b1;
            up_kind = K_REL_IND;
          end
        end
        M_ESTAB: begin
          if (ev == dlc_pkg::EV_REL_IND) begin
            do_go_down = 1'b1;
            up_kind = K_REL_IND;
          end else if (ev == dlc_pkg::EV_REL_REQ) begin
            do_start = 1'b1;
          end
        end
        M_REL_DELAY: begin
          if (ev == dlc_pkg::EV_REL_IND) begin
            do_go_down = 1'b1;
            up_kind = K_REL_IND;
          end else if (ev == dlc_pkg::EV_EST_REQ) begin
            do_come_up = 1'b1;
            up_kind = K_EST_CNF;
          end else if (ev == dlc_pkg::EV_DELAY_EXPIRED) begin
            if (cmd.blocked) begin
              do_start = 1'b1;
            end else begin
              mode_next = M_REL_WAIT;
              post_v_next = 1'b1;
              post_kind_next = K_REL_REQ;
            end
          end
        end
        M_REL_WAIT: begin
          if (ev == dlc_pkg::EV_REL_CNF) begin
            do_go_down = 1'b1;
            up_kind = K_REL_CNF;
          end else if (ev == dlc_pkg::EV_EST_REQ) begin
            do_activate = 1'b1;
          end
        end
        default: mode_next = M_REL;
      endcase
    end

    if (do_activate) begin
      mode_next = M_EST_WAIT;
      post_v_next = 1'b1;
      post_kind_next = K_EST_REQ;
    end
    if (do_start) begin
      mode_next = M_REL_DELAY;
      delay_count_next = release_delay_ticks;
      delay_running_next = 1'b1;
    end
    if (do_come_up) begin
      mode_next = M_ESTAB;
      delay_count_next = '0;
      delay_running_next = 1'b0;
      drain_n_next = pending_count_next;
      drain_v_next = (pending_count_next != '0);
      pending_count_next = '0;
      if (!cmd.procs && drain_v_next) begin
        mode_next = M_REL_DELAY;
        delay_count_next = release_delay_ticks;
        delay_running_next = 1'b1;
      end else begin
        post_v_next = 1'b1;
        post_kind_next = up_kind;
      end
    end
    if (do_go_down) begin
      mode_next = M_REL;
      delay_count_next = '0;
      delay_running_next = 1'b0;
      post_disc_next = pending_count_next;
      pending_count_next = '0;
      post_v_next = 1'b1;
      post_kind_next = up_kind;
    end

    if (!pre_v_next && !drain_v_next && !post_v_next) begin
      post_v_next = 1'b1;
      post_kind_next = K_NONE;
    end
  end

  assign room = (o_cnt != 2'd2);
  assign drain_end = (drain_idx + CW'(1) == drain_n);
  assign disc_ext = {{dlc_pkg::DISC_W{1'b0}}, post_disc};

  always_comb begin
    emit_v = 1'b0;
    emit_res.kind = K_NONE;
    emit_res.handle = '0;
    emit_res.id = '0;
    emit_res.up = 1'b0;
    emit_res.disc = '0;
    emit_res.state = final_mode;
    emit_res.last = 1'b0;
    case (bstate)
      B_PRE: begin
        emit_v = room;
        emit_res.kind = pre_kind;
        emit_res.handle = pre_handle;
        emit_res.id = pre_id;
        emit_res.up = pre_up;
        emit_res.last = !drain_v && !post_v;
      end
      B_DRAIN: begin
        emit_v = room;
        emit_res.kind = K_DATA;
        emit_res.handle = rd_data;
        emit_res.id = {entity_id, 1'b0, next_sequence};
        emit_res.last = drain_end && !post_v;
      end
      B_POST: begin
        emit_v = room;
        emit_res.kind = post_kind;
        emit_res.disc = disc_ext[dlc_pkg::DISC_W-1:0];
        emit_res.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && wr_en) begin
      pending_queue[pending_count[AW-1:0]] <= cmd.handle;
    end
    rd_data <= pending_queue[drain_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (emit_v) begin
      oq[o_wr] <= emit_res;
    end
  end

  assign res_empty = (o_cnt == 2'd0);
  assign res_head = oq[o_rd];
  assign do_res_pop = res_pop && !res_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate <= B_IDLE;
      link_mode <= M_REL;
      delay_count <= '0;
      delay_running <= 1'b0;
      next_sequence <= 15'd1;
      pending_count <= '0;
      o_wr <= 1'b0;
      o_rd <= 1'b0;
      o_cnt <= 2'd0;
      pre_v <= 1'b0;
      drain_v <= 1'b0;
      post_v <= 1'b0;
    end else begin
      if (emit_v) begin
        o_wr <= ~o_wr;
      end
      if (do_res_pop) begin
        o_rd <= ~o_rd;
      end
      case ({emit_v, do_res_pop})
        2'b10:   o_cnt <= o_cnt + 2'd1;
        2'b01:   o_cnt <= o_cnt - 2'd1;
        default: o_cnt <= o_cnt;
      endcase

      case (bstate)
        B_IDLE: begin
          if (cmd_valid) begin
            link_mode <= mode_next;
            delay_count <= delay_count_next;
            delay_running <= delay_running_next;
            next_sequence <= next_sequence_next;
            pending_count <= pending_count_next;
            pre_v <= pre_v_next;
            pre_kind <= pre_kind_next;
            pre_handle <= pre_handle_next;
            pre_id <= pre_id_next;
            pre_up <= pre_up_next;
            drain_v <= drain_v_next;
            drain_n <= drain_n_next;
            drain_idx <= '0;
            post_v <= post_v_next;
            post_kind <= post_kind_next;
            post_disc <= post_disc_next;
            final_mode <= mode_next;
            if (pre_v_next) begin
              bstate <= B_PRE;
            end else if (drain_v_next) begin
              bstate <= B_FETCH;
            end else begin
              bstate <= B_POST;
            end
          end
        end
        B_PRE: begin
          if (room) begin
            if (drain_v) begin
              bstate <= B_FETCH;
            end else if (post_v) begin
              bstate <= B_POST;
            end else begin
              bstate <= B_IDLE;
            end
          end
        end
        B_FETCH: bstate <= B_DRAIN;
        B_DRAIN: begin
          if (room) begin
            next_sequence <= seq_wrap;
            drain_idx <= drain_idx + CW'(1);
            if (!drain_end) begin
              bstate <= B_FETCH;
            end else if (post_v) begin
              bstate <= B_POST;
            end else begin
              bstate <= B_IDLE;
            end
          end
        end
        B_POST: begin
          if (room) begin
            bstate <= B_IDLE;
          end
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

endmodule

/* design/data_link_control_fsm_core.sv */
`timescale 1ns / 1ps
// An accepted item is registered in the front queue and is taken by the back end
// only while the back end is idle; its results are registered in the output queue
// before they show on the result ports. Each queued handle drained on link
// establishment passes through a memory read state and then an emit state.
// Synchronous reset empties the command, pending and result queues, releases the
// link and restores the configuration registers to their defaults; the pending memory is not cleared.

module data_link_control_fsm_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [dlc_pkg::FUNC_W-1:0]        func,
  input  logic [dlc_pkg::HANDLE_W-1:0]      msg_handle,
  input  logic                              processes_active,
  input  logic                              l2_blocked,
  output logic                              empty,
  input  logic                              pop,
  output logic [dlc_pkg::KIND_W-1:0]        kind,
  output logic [dlc_pkg::HANDLE_W-1:0]      out_handle,
  output logic [dlc_pkg::ID_W-1:0]          msg_id,
  output logic                              link_up,
  output logic [dlc_pkg::DISC_W-1:0]        discarded,
  output logic [dlc_pkg::STATE_W-1:0]       link_state,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dlc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dlc_pkg::CFG_W-1:0]         cfg_data
);

  logic [dlc_pkg::CFG_W-1:0] release_delay_ticks;
  logic [dlc_pkg::CFG_W-1:0] entity_id;
  logic                      cmd_valid;
  logic                      cmd_pop;
  dlc_pkg::cmd_t             cmd;
  dlc_pkg::res_t             res_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_delay_ticks <= dlc_pkg::RELEASE_DELAY_RESET;
      entity_id <= dlc_pkg::ENTITY_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dlc_pkg::REG_RELEASE_DELAY: release_delay_ticks <= cfg_data;
        dlc_pkg::REG_ENTITY_ID:     entity_id <= cfg_data;
        default: ;
      endcase
    end
  end

  dlc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .func             (func),
    .msg_handle       (msg_handle),
    .processes_active (processes_active),
    .l2_blocked       (l2_blocked),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop)
  );

  dlc_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .cmd_valid           (cmd_valid),
    .cmd                 (cmd),
    .cmd_pop             (cmd_pop),
    .release_delay_ticks (release_delay_ticks),
    .entity_id           (entity_id),
    .res_empty           (empty),
    .res_head            (res_head),
    .res_pop             (pop)
  );

  assign kind = res_head.kind;
  assign out_handle = res_head.handle;
  assign msg_id = res_head.id;
  assign link_up = res_head.up;
  assign discarded = res_head.disc;
  assign link_state = res_head.state;
  assign last = res_head.last;

endmodule

/* tb/link_ctrl_checker.sv */
`timescale 1ns / 1ps

module link_ctrl_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          full,
  input  logic [dlc_pkg::FUNC_W-1:0]    func,
  input  logic [dlc_pkg::HANDLE_W-1:0]  msg_handle,
  input  logic                          processes_active,
  input  logic                          l2_blocked,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [dlc_pkg::KIND_W-1:0]    kind,
  input  logic [dlc_pkg::HANDLE_W-1:0]  out_handle,
  input  logic [dlc_pkg::ID_W-1:0]      msg_id,
  input  logic                          link_up,
  input  logic [dlc_pkg::DISC_W-1:0]    discarded,
  input  logic [dlc_pkg::STATE_W-1:0]   link_state,
  input  logic                          last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [dlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlc_pkg::CFG_W-1:0]     cfg_data,
  output int unsigned                   fail_count,
  output int unsigned                   results_due
);

  localparam logic [14:0] SEQ_LAST = 15'h7fff;

  logic [dlc_pkg::CFG_W-1:0]    delay_ticks;
  logic [dlc_pkg::CFG_W-1:0]    entity_no;
  logic [dlc_pkg::STATE_W-1:0]  link_mode;
  logic [dlc_pkg::CFG_W-1:0]    delay_left;
  logic                         delay_on;
  logic [14:0]                  next_seq;
  logic [dlc_pkg::HANDLE_W-1:0] backlog [QUEUE_DEPTH];
  int unsigned                  backlog_cnt;
  logic                         procs_now;
  logic                         blocked_now;
  dlc_pkg::res_t                step_results[$];
  dlc_pkg::res_t                due_results[$];
  int unsigned                  errors;

  task automatic emit(input logic [dlc_pkg::KIND_W-1:0] k,
                      input logic [dlc_pkg::HANDLE_W-1:0] h,
                      input logic [dlc_pkg::ID_W-1:0] id, input logic up,
                      input logic [dlc_pkg::DISC_W-1:0] n);
    dlc_pkg::res_t r;
    r = '0;
    r.kind = k;
    r.handle = h;
    r.id = id;
    r.up = up;
    r.disc = n;
    step_results.push_back(r);
  endtask

  function automatic logic [dlc_pkg::ID_W-1:0] take_id();
    logic [14:0] seq;
    seq = next_seq;
    next_seq = (seq == SEQ_LAST) ? 15'd1 : seq + 15'd1;
    return {entity_no, 1'b0, seq};
  endfunction

  task automatic start_delay();
    link_mode = dlc_pkg::LINK_REL_DELAY;
    delay_left = delay_ticks;
    delay_on = 1'b1;
  endtask

  task automatic activate();
    link_mode = dlc_pkg::LINK_EST_WAIT;
    emit(dlc_pkg::KIND_EST_REQ, '0, '0, 1'b0, '0);
  endtask

  task automatic come_up(input logic [dlc_pkg::KIND_W-1:0] up_kind);
    int unsigned n;
    n = backlog_cnt;
    delay_on = 1'b0;
    delay_left = '0;
    link_mode = dlc_pkg::LINK_ESTAB;
    for (int i = 0; i < n; i++) emit(dlc_pkg::KIND_DATA, backlog[i], take_id(), 1'b0, '0);
    backlog_cnt = 0;
    if (!procs_now && n > 0) start_delay();
    else emit(up_kind, '0, '0, 1'b0, '0);
  endtask

  task automatic go_down(input logic [dlc_pkg::KIND_W-1:0] down_kind);
    int unsigned n;
    n = backlog_cnt;
    delay_on = 1'b0;
    delay_left = '0;
    link_mode = dlc_pkg::LINK_REL;
    backlog_cnt = 0;
    emit(down_kind, '0, '0, 1'b0, n[dlc_pkg::DISC_W-1:0]);
  endtask

  task automatic on_event(input dlc_pkg::ev_t ev);
    case (link_mode)
      dlc_pkg::LINK_REL: begin
        if (ev == dlc_pkg::EV_EST_REQ) activate();
        else if (ev == dlc_pkg::EV_EST_IND || ev == dlc_pkg::EV_EST_CNF)
          come_up(dlc_pkg::KIND_EST_IND);
      end
      dlc_pkg::LINK_EST_WAIT: begin
        if (ev == dlc_pkg::EV_EST_CNF) come_up(dlc_pkg::KIND_EST_CNF);
        else if (ev == dlc_pkg::EV_REL_REQ) start_delay();
        else if (ev == dlc_pkg::EV_REL_IND) go_down(dlc_pkg::KIND_REL_IND);
      end
      dlc_pkg::LINK_ESTAB: begin
        if (ev == dlc_pkg::EV_REL_IND) go_down(dlc_pkg::KIND_REL_IND);
        else if (ev == dlc_pkg::EV_REL_REQ) start_delay();
      end
      dlc_pkg::LINK_REL_DELAY: begin
        if (ev == dlc_pkg::EV_REL_IND) begin
          go_down(dlc_pkg::KIND_REL_IND);
        end else if (ev == dlc_pkg::EV_EST_REQ) begin
          come_up(dlc_pkg::KIND_EST_CNF);
        end else if (ev == dlc_pkg::EV_DELAY_EXPIRED) begin
          if (blocked_now) begin
            start_delay();
          end else begin
            link_mode = dlc_pkg::LINK_REL_WAIT;
            emit(dlc_pkg::KIND_REL_REQ, '0, '0, 1'b0, '0);
          end
        end
      end
      dlc_pkg::LINK_REL_WAIT: begin
        if (ev == dlc_pkg::EV_REL_CNF) go_down(dlc_pkg::KIND_REL_CNF);
        else if (ev == dlc_pkg::EV_EST_REQ) activate();
      end
      default: link_mode = dlc_pkg::LINK_REL;
    endcase
  endtask

  task automatic advance_link(input logic [dlc_pkg::FUNC_W-1:0] f,
                              input logic [dlc_pkg::HANDLE_W-1:0] h,
                              input logic procs, input logic blocked);
    step_results.delete();
    procs_now = procs;
    blocked_now = blocked;
    case (f)
      dlc_pkg::FUNC_DATA_REQ: begin
        if (link_mode == dlc_pkg::LINK_ESTAB) begin
          emit(dlc_pkg::KIND_DATA, h, take_id(), 1'b0, '0);
        end else begin
          if (backlog_cnt < QUEUE_DEPTH) begin
            backlog[backlog_cnt] = h;
            backlog_cnt++;
          end else begin
            emit(dlc_pkg::KIND_DROPPED, h, '0, 1'b0, '0);
          end
          on_event(dlc_pkg::EV_EST_REQ);
        end
      end
      dlc_pkg::FUNC_STATUS_REQ:
        emit(dlc_pkg::KIND_STATUS, '0, '0, link_mode == dlc_pkg::LINK_ESTAB, '0);
      dlc_pkg::FUNC_EST_REQ: on_event(dlc_pkg::EV_EST_REQ);
      dlc_pkg::FUNC_EST_CNF: on_event(dlc_pkg::EV_EST_CNF);
      dlc_pkg::FUNC_EST_IND: on_event(dlc_pkg::EV_EST_IND);
      dlc_pkg::FUNC_REL_IND: on_event(dlc_pkg::EV_REL_IND);
      dlc_pkg::FUNC_REL_CNF: on_event(dlc_pkg::EV_REL_CNF);
      dlc_pkg::FUNC_REL_REQ: on_event(dlc_pkg::EV_REL_REQ);
      dlc_pkg::FUNC_TICK: begin
        if (delay_on) begin
          if (delay_left > 1) begin
            delay_left--;
          end else begin
            delay_left = '0;
            delay_on = 1'b0;
            on_event(dlc_pkg::EV_DELAY_EXPIRED);
          end
        end
      end
      default: ;
    endcase
    if (step_results.size() == 0) emit(dlc_pkg::KIND_NONE, '0, '0, 1'b0, '0);
    foreach (step_results[i]) begin
      step_results[i].state = link_mode;
      step_results[i].last = (i == step_results.size() - 1);
      due_results.push_back(step_results[i]);
    end
  endtask

  task automatic check_field(input string name, input logic [dlc_pkg::ID_W-1:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    dlc_pkg::res_t want;
    if (rst) begin
      delay_ticks = dlc_pkg::RELEASE_DELAY_RESET;
      entity_no = dlc_pkg::ENTITY_ID_RESET;
      link_mode = dlc_pkg::LINK_REL;
      delay_left = '0;
      delay_on = 1'b0;
      next_seq = 15'd1;
      backlog_cnt = 0;
      due_results.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dlc_pkg::REG_RELEASE_DELAY) delay_ticks = cfg_data;
        else if (cfg_index == dlc_pkg::REG_ENTITY_ID) entity_no = cfg_data;
      end
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          $error("kind: expected no result item, got %0h", kind);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", want.kind, kind);
          check_field("out_handle", want.handle, out_handle);
          check_field("msg_id", want.id, msg_id);
          check_field("link_up", want.up, link_up);
          check_field("discarded", want.disc, discarded);
          check_field("link_state", want.state, link_state);
          check_field("last", want.last, last);
        end
      end
      if (push && !full) advance_link(func, msg_handle, processes_active, l2_blocked);
    end
    fail_count <= errors;
    results_due <= due_results.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int QUEUE_DEPTH = 16;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [dlc_pkg::FUNC_W-1:0] FUNC_MAX = '1;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          push = 1'b0;
  logic                          full;
  logic [dlc_pkg::FUNC_W-1:0]    func = dlc_pkg::FUNC_STATUS_REQ;
  logic [dlc_pkg::HANDLE_W-1:0]  msg_handle = '0;
  logic                          processes_active = 1'b0;
  logic                          l2_blocked = 1'b0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic [dlc_pkg::KIND_W-1:0]    kind;
  logic [dlc_pkg::HANDLE_W-1:0]  out_handle;
  logic [dlc_pkg::ID_W-1:0]      msg_id;
  logic                          link_up;
  logic [dlc_pkg::DISC_W-1:0]    discarded;
  logic [dlc_pkg::STATE_W-1:0]   link_state;
  logic                          last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [dlc_pkg::CFG_IDX_W-1:0] cfg_index = dlc_pkg::REG_RELEASE_DELAY;
  logic [dlc_pkg::CFG_W-1:0]     cfg_data = '0;
  int unsigned                   fail_count;
  int unsigned                   results_due;
  logic                          hold_req = 1'b0;
  logic                          hold_done = 1'b0;
  int unsigned                   sink_wait = 0;
  int unsigned                   cycle_cnt = 0;

  data_link_control_fsm_core #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (.*);

  link_ctrl_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    else if (roll < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  task automatic offer(input logic [dlc_pkg::FUNC_W-1:0] f,
                       input logic [dlc_pkg::HANDLE_W-1:0] h,
                       input logic procs, input logic blocked, input bit paced);
    int unsigned gap;
    gap = paced ? idle_cycles() : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    func <= f;
    msg_handle <= h;
    processes_active <= procs;
    l2_blocked <= blocked;
    do @(posedge clk); while (full);
  endtask

  task automatic random_item(input bit paced);
    int unsigned roll;
    logic [dlc_pkg::FUNC_W-1:0] f;
    roll = $urandom_range(0, 99);
    if (roll < 30) f = dlc_pkg::FUNC_DATA_REQ;
    else if (roll < 50) f = dlc_pkg::FUNC_TICK;
    else if (roll < 58) f = dlc_pkg::FUNC_EST_CNF;
    else if (roll < 64) f = dlc_pkg::FUNC_EST_IND;
    else if (roll < 69) f = dlc_pkg::FUNC_EST_REQ;
    else if (roll < 76) f = dlc_pkg::FUNC_REL_IND;
    else if (roll < 84) f = dlc_pkg::FUNC_REL_CNF;
    else if (roll < 91) f = dlc_pkg::FUNC_REL_REQ;
    else if (roll < 96) f = dlc_pkg::FUNC_STATUS_REQ;
    else f = dlc_pkg::FUNC_W'($urandom_range(dlc_pkg::FUNC_TICK + 1, FUNC_MAX));
    offer(f, dlc_pkg::HANDLE_W'($urandom()), 1'($urandom_range(0, 1)),
          $urandom_range(0, 3) == 0, paced);
  endtask

  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic program_link(input logic [dlc_pkg::CFG_W-1:0] ticks,
                              input logic [dlc_pkg::CFG_W-1:0] ent);
    cfg_valid <= 1'b1;
    cfg_index <= dlc_pkg::REG_RELEASE_DELAY;
    cfg_data <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= dlc_pkg::REG_ENTITY_ID;
    cfg_data <= ent;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : result_sink
    int unsigned gap;
    if (rst) begin
      pop <= 1'b0;
      sink_wait <= 0;
    end else if (hold_req && !hold_done) begin
      pop <= 1'b0;
      hold_done <= 1'b1;
      sink_wait <= HOLD_CYCLES;
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
    end else if (pop && !empty) begin
      gap = idle_cycles();
      pop <= (gap == 0);
      sink_wait <= gap;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // A zero release delay expires on the first tick.
    program_link('0, '0);
    offer(dlc_pkg::FUNC_STATUS_REQ, '0, 1'b0, 1'b0, 1'b1);
    offer(dlc_pkg::FUNC_TICK, '0, 1'b0, 1'b0, 1'b1);
    offer(FUNC_MAX, '1, 1'b1, 1'b1, 1'b1);
    offer(dlc_pkg::FUNC_EST_IND, '0, 1'b1, 1'b0, 1'b1);
    offer(dlc_pkg::FUNC_DATA_REQ, '1, 1'b1, 1'b0, 1'b1);
    offer(dlc_pkg::FUNC_REL_REQ, '0, 1'b1, 1'b0, 1'b1);
    offer(dlc_pkg::FUNC_TICK, '0, 1'b0, 1'b1, 1'b1);
    offer(dlc_pkg::FUNC_TICK, '0, 1'b0, 1'b0, 1'b1);
    offer(dlc_pkg::FUNC_REL_CNF, '0, 1'b0, 1'b0, 1'b1);
    offer(dlc_pkg::FUNC_EST_CNF, '0, 1'b1, 1'b0, 1'b1);
    offer(dlc_pkg::FUNC_REL_IND, '0, 1'b0, 1'b0, 1'b1);
    // Fill the pending queue and overflow it by one.
    for (int i = 0; i <= QUEUE_DEPTH; i++)
      offer(dlc_pkg::FUNC_DATA_REQ,
            (i == 0) ? '1 : (i == 1) ? '0 : dlc_pkg::HANDLE_W'($urandom()),
            1'b0, 1'b0, 1'b1);
    offer(dlc_pkg::FUNC_EST_CNF, '0, 1'b0, 1'b0, 1'b1);
    offer(dlc_pkg::FUNC_EST_REQ, '0, 1'b1, 1'b0, 1'b1);

    settle();
    program_link(16'd1, dlc_pkg::CFG_W'($urandom()));
    repeat (PHASE_ITEMS) random_item(1'b1);

    settle();
    program_link(16'd3, dlc_pkg::CFG_W'($urandom()));
    repeat (PHASE_ITEMS) random_item(1'b1);

    settle();
    program_link(16'd2, '1);
    hold_req <= 1'b1;
    repeat (2 * PHASE_ITEMS) random_item(1'b0);

    settle();
    program_link('1, dlc_pkg::CFG_W'($urandom()));
    repeat (PHASE_ITEMS) random_item(1'b1);

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
design/dlc_pkg.sv
design/dlc_front.sv
design/dlc_back.sv
design/data_link_control_fsm_core.sv
tb/link_ctrl_checker.sv
tb/tb.sv
